// File: rtl/carq_pkg.sv
// ============================================================================
// carq_pkg
// Shared types and constants for the command ack / retry engine.
// ============================================================================
package carq_pkg;

    // Field widths
    localparam int CMD_W     = 2;
    localparam int ID_W      = 16;
    localparam int TAG_W     = 8;
    localparam int CODE_W    = 8;
    localparam int RETRY_W   = 4;
    localparam int TIMEOUT_W = 16;
    localparam int TIMER_W   = 20;
    localparam int STATUS_W  = 3;

    // Stream packing
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 32;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Defaults
    localparam int DEF_QUEUE_DEPTH = 8;
    localparam logic [RETRY_W-1:0]   RETRY_LIMIT_RST   = 4'd3;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_TICKS_RST = 16'd500;

    // Event queue between front and back
    localparam int EVQ_DEPTH = 2;
    localparam int EVQ_AW    = $clog2(EVQ_DEPTH);
    localparam int EVQ_CW    = $clog2(EVQ_DEPTH + 1);

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RETRY_LIMIT   = 2'd0,
        REG_TIMEOUT_TICKS = 2'd1
    } reg_idx_t;

    // Input command codes
    typedef enum logic [CMD_W-1:0] {
        OP_ENQUEUE = 2'd0,
        OP_ACK     = 2'd1,
        OP_POLL    = 2'd2,
        OP_TICK    = 2'd3
    } op_t;

    // Acknowledgement result codes
    typedef enum logic [CODE_W-1:0] {
        ACK_ACCEPTED    = 8'd0,
        ACK_TEMP_REJECT = 8'd1,
        ACK_DENIED      = 8'd2,
        ACK_UNSUPPORTED = 8'd3,
        ACK_FAILED      = 8'd4,
        ACK_IN_PROGRESS = 8'd5
    } ack_code_t;

    // Acknowledgement classes seen by the back end
    typedef enum logic [1:0] {
        ACLS_SUCCESS,
        ACLS_DENY,
        ACLS_PROGRESS,
        ACLS_IGNORE
    } ack_class_t;

    // Completion status
    typedef enum logic [STATUS_W-1:0] {
        ST_SUCCESS  = 3'd0,
        ST_DENIED   = 3'd1,
        ST_CONN_ERR = 3'd2,
        ST_TIMEOUT  = 3'd3,
        ST_QFULL    = 3'd4
    } status_t;

    // Result kind
    localparam logic KIND_TX   = 1'b0;
    localparam logic KIND_DONE = 1'b1;

    // Classified event word
    typedef struct packed {
        op_t              op;
        logic [ID_W-1:0]  id;
        logic [TAG_W-1:0] tag;
        ack_class_t       acls;
        logic             link;
    } event_t;

    // Live configuration
    typedef struct packed {
        logic [RETRY_W-1:0]   retry_limit;
        logic [TIMEOUT_W-1:0] timeout_ticks;
    } cfg_t;

endpackage

// File: rtl/command_ack_retry_engine_unit.sv
// ============================================================================
// command_ack_retry_engine_unit
// Stop-and-wait command engine with acknowledgement matching and retries.
// ============================================================================
// Path: an accepted input word passes the event queue, then the result
// register, before its result appears on the result stream.
// Throughput: one word per cycle unless the result stream stalls; an enqueue
// into an empty queue or any completion holds the next event for a head re-read.
// Reset: synchronous active-low aresetn empties both queues, clears the timer
// and loads retry_limit = 3, timeout_ticks = 500; command memory is not cleared.
module command_ack_retry_engine_unit #(
    parameter int QUEUE_DEPTH = carq_pkg::DEF_QUEUE_DEPTH
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration write port
    input  logic                              cfg_we,
    input  logic [carq_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [carq_pkg::CFG_DATA_W-1:0]   cfg_data,
    // input stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [15:0] command_id, [23:16] message_tag, [31:24] ack_result, [32] link_ok
    input  logic [carq_pkg::S_TDATA_W-1:0]    s_tdata,
    // [1:0] command
    input  logic [carq_pkg::CMD_W-1:0]        s_tuser,
    // result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [7:0] out_tag, [23:8] out_command_id, [26:24] out_status
    output logic [carq_pkg::M_TDATA_W-1:0]    m_tdata,
    // [0] out_kind
    output logic                              m_tuser
);
    import carq_pkg::*;

    cfg_t    cfg_reg;
    logic    ev_valid;
    event_t  ev_word;
    logic    ev_pop;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.retry_limit   <= RETRY_LIMIT_RST;
            cfg_reg.timeout_ticks <= TIMEOUT_TICKS_RST;
        end else if (cfg_we) begin
            if (cfg_index == REG_RETRY_LIMIT) begin
                cfg_reg.retry_limit <= cfg_data[RETRY_W-1:0];
            end else if (cfg_index == REG_TIMEOUT_TICKS) begin
                cfg_reg.timeout_ticks <= cfg_data[TIMEOUT_W-1:0];
            end
        end
    end

    carq_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .ev_valid (ev_valid),
        .ev_word  (ev_word),
        .ev_pop   (ev_pop)
    );

    carq_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .ev_valid (ev_valid),
        .ev_word  (ev_word),
        .ev_pop   (ev_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

// File: rtl/carq_front.sv
// ============================================================================
// carq_front
// Accepts input words, classifies them and queues them for the back end.
// ============================================================================
module carq_front (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // [15:0] command_id, [23:16] message_tag, [31:24] ack_result, [32] link_ok
    input  logic [carq_pkg::S_TDATA_W-1:0]   s_tdata,
    // [1:0] command
    input  logic [carq_pkg::CMD_W-1:0]       s_tuser,
    output logic                             ev_valid,
    output carq_pkg::event_t                 ev_word,
    input  logic                             ev_pop
);
    import carq_pkg::*;

    event_t              evq_mem [EVQ_DEPTH];
    logic [EVQ_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [EVQ_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [EVQ_CW-1:0]   cnt_reg, cnt_next;
    event_t              cls_word;
    logic                push;
    logic                pop;
    logic [CODE_W-1:0]   code;

    // classify the incoming word
    always_comb begin
        code          = s_tdata[31:24];
        cls_word.op   = op_t'(s_tuser);
        cls_word.id   = s_tdata[15:0];
        cls_word.tag  = s_tdata[23:16];
        cls_word.link = s_tdata[32];
        unique case (code)
            ACK_ACCEPTED:    cls_word.acls = ACLS_SUCCESS;
            ACK_TEMP_REJECT,
            ACK_DENIED,
            ACK_UNSUPPORTED,
            ACK_FAILED:      cls_word.acls = ACLS_DENY;
            ACK_IN_PROGRESS: cls_word.acls = ACLS_PROGRESS;
            default:         cls_word.acls = ACLS_IGNORE;
        endcase
    end

    assign s_tready = (cnt_reg != EVQ_CW'(EVQ_DEPTH));
    assign push     = s_tvalid && s_tready;
    assign pop      = ev_pop && ev_valid;
    assign ev_valid = (cnt_reg != '0);
    assign ev_word  = evq_mem[rd_ptr_reg];

    // pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == EVQ_AW'(EVQ_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == EVQ_AW'(EVQ_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // event storage
    always_ff @(posedge aclk) begin
        if (push) begin
            evq_mem[wr_ptr_reg] <= cls_word;
        end
    end

endmodule

// File: rtl/carq_back.sv
// ============================================================================
// carq_back
// Command queue, retry timer, result reg; one event per cycle unless stalled.
// ============================================================================
module carq_back #(
    parameter int QUEUE_DEPTH = carq_pkg::DEF_QUEUE_DEPTH
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  carq_pkg::cfg_t                   cfg,
    input  logic                             ev_valid,
    input  carq_pkg::event_t                 ev_word,
    output logic                             ev_pop,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [7:0] out_tag, [23:8] out_command_id, [26:24] out_status
    output logic [carq_pkg::M_TDATA_W-1:0]   m_tdata,
    // [0] out_kind
    output logic                             m_tuser
);
    import carq_pkg::*;

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    // command memory
    logic [ID_W-1:0]    id_mem  [QUEUE_DEPTH];
    logic [TAG_W-1:0]   tag_mem [QUEUE_DEPTH];
    logic [ID_W-1:0]    rd_id_reg;
    logic [TAG_W-1:0]   rd_tag_reg;

    // control state
    logic [AW-1:0]      head_reg, head_next;
    logic [CW-1:0]      count_reg, count_next;
    logic               sent_reg, sent_next;
    logic [RETRY_W-1:0] retries_reg, retries_next;
    logic [TIMER_W-1:0] timer_reg, timer_next;
    logic               armed_reg, armed_next;
    logic               hold_reg, hold_next;

    // result register
    logic               out_valid_reg;
    logic               out_kind_reg;
    logic [TAG_W-1:0]   out_tag_reg;
    logic [ID_W-1:0]    out_id_reg;
    status_t            out_status_reg;

    logic               go;
    logic               res_valid;
    logic               res_kind;
    logic [TAG_W-1:0]   res_tag;
    logic [ID_W-1:0]    res_id;
    status_t            res_status;
    logic               wr_en;
    logic [AW-1:0]      wr_slot;
    logic [CW:0]        slot_sum;
    logic [TIMER_W-1:0] prog_ticks;

    assign go     = ev_valid && !hold_reg && (!out_valid_reg || m_tready);
    assign ev_pop = go;

    assign slot_sum   = (CW + 1)'(head_reg) + (CW + 1)'(count_reg);
    assign wr_slot    = (slot_sum >= (CW + 1)'(QUEUE_DEPTH))
                        ? AW'(slot_sum - (CW + 1)'(QUEUE_DEPTH)) : AW'(slot_sum);
    assign prog_ticks = TIMER_W'(retries_reg) * TIMER_W'(cfg.timeout_ticks);

    // event processing
    always_comb begin
        logic complete;
        logic transmit;
        status_t cst;
        complete     = 1'b0;
        transmit     = 1'b0;
        cst          = ST_SUCCESS;
        head_next    = head_reg;
        count_next   = count_reg;
        sent_next    = sent_reg;
        retries_next = retries_reg;
        timer_next   = timer_reg;
        armed_next   = armed_reg;
        hold_next    = 1'b0;
        wr_en        = 1'b0;
        res_valid    = 1'b0;
        res_kind     = KIND_DONE;
        res_tag      = rd_tag_reg;
        res_id       = rd_id_reg;
        res_status   = ST_SUCCESS;

        if (go) begin
            if (ev_word.op == OP_ENQUEUE) begin
                if (count_reg == CW'(QUEUE_DEPTH)) begin
                    res_valid  = 1'b1;
                    res_tag    = ev_word.tag;
                    res_id     = ev_word.id;
                    res_status = ST_QFULL;
                end else begin
                    wr_en      = 1'b1;
                    count_next = count_reg + 1'b1;
                    // head read data goes stale when the first entry lands
                    hold_next  = (count_reg == '0);
                end
            end else if (count_reg != '0) begin
                unique case (ev_word.op)
                    OP_ACK: begin
                        if (rd_id_reg == ev_word.id) begin
                            unique case (ev_word.acls)
                                ACLS_SUCCESS: begin
                                    complete = 1'b1;
                                    cst      = ST_SUCCESS;
                                end
                                ACLS_DENY: begin
                                    complete = 1'b1;
                                    cst      = ST_DENIED;
                                end
                                ACLS_PROGRESS: begin
                                    timer_next = prog_ticks;
                                    armed_next = 1'b1;
                                end
                                ACLS_IGNORE: begin
                                end
                            endcase
                        end
                    end
                    OP_POLL: begin
                        if (!sent_reg) begin
                            if (!ev_word.link) begin
                                complete = 1'b1;
                                cst      = ST_CONN_ERR;
                            end else begin
                                transmit     = 1'b1;
                                sent_next    = 1'b1;
                                retries_next = cfg.retry_limit;
                                timer_next   = TIMER_W'(cfg.timeout_ticks);
                                armed_next   = 1'b1;
                            end
                        end
                    end
                    OP_TICK: begin
                        if (armed_reg) begin
                            if (timer_reg > TIMER_W'(1)) begin
                                timer_next = timer_reg - 1'b1;
                            end else if (retries_reg == '0) begin
                                complete = 1'b1;
                                cst      = ST_TIMEOUT;
                            end else if (!ev_word.link) begin
                                complete = 1'b1;
                                cst      = ST_CONN_ERR;
                            end else begin
                                transmit     = 1'b1;
                                retries_next = retries_reg - 1'b1;
                                timer_next   = TIMER_W'(cfg.timeout_ticks);
                                armed_next   = 1'b1;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end

            // pop the front on completion
            if (complete) begin
                res_valid  = 1'b1;
                res_status = cst;
                head_next  = (head_reg == AW'(QUEUE_DEPTH - 1)) ? '0 : head_reg + 1'b1;
                count_next = count_reg - 1'b1;
                sent_next  = 1'b0;
                armed_next = 1'b0;
                timer_next = '0;
                hold_next  = 1'b1;
            end else if (transmit) begin
                res_valid = 1'b1;
                res_kind  = KIND_TX;
            end
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg      <= '0;
            count_reg     <= '0;
            sent_reg      <= 1'b0;
            retries_reg   <= '0;
            timer_reg     <= '0;
            armed_reg     <= 1'b0;
            hold_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            head_reg    <= head_next;
            count_reg   <= count_next;
            sent_reg    <= sent_next;
            retries_reg <= retries_next;
            timer_reg   <= timer_next;
            armed_reg   <= armed_next;
            hold_reg    <= hold_next;
            if (go && res_valid) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (go && res_valid) begin
            out_kind_reg   <= res_kind;
            out_tag_reg    <= res_tag;
            out_id_reg     <= res_id;
            out_status_reg <= res_status;
        end
    end

    // command memory: write on enqueue, registered read of the head slot
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            id_mem[wr_slot]  <= ev_word.id;
            tag_mem[wr_slot] <= ev_word.tag;
        end
        rd_id_reg  <= id_mem[head_reg];
        rd_tag_reg <= tag_mem[head_reg];
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tdata  = {5'b0, out_status_reg, out_id_reg, out_tag_reg};

endmodule

// File: tb/command_ack_retry_engine_unit_test.sv
// ============================================================================
// command_ack_retry_engine_unit_test
// Self-checking bench for the stop-and-wait command engine. A scoreboard
// class tracks the pending-command queue, the in-flight flag, the retry
// count and the tick timer, and predicts every transmit and completion
// word. The bench runs a directed pass over the corner cases, then random
// phases under several retry and timeout settings, with random gaps and
// stalls on both stream ports.
// ============================================================================
module command_ack_retry_engine_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import carq_pkg::*;

    localparam int QDEPTH       = DEF_QUEUE_DEPTH;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 8;
    localparam int TAIL_CYCLES  = 16;

    // Unmapped register slots; writes there must be ignored
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

    typedef struct packed {
        logic             kind;
        logic [TAG_W-1:0] tag;
        logic [ID_W-1:0]  id;
        status_t          status;
    } result_t;

    // ------------------------------------------------------------------------
    // Scoreboard: command queue, timer and retry state, expected results
    // ------------------------------------------------------------------------
    class ack_retry_scoreboard;
        logic [ID_W-1:0]      id_mem [QDEPTH];
        logic [TAG_W-1:0]     tag_mem[QDEPTH];
        int unsigned          head;
        int unsigned          count;
        bit                   in_flight;
        logic [RETRY_W-1:0]   retries;
        logic [TIMER_W-1:0]   timer;
        bit                   armed;
        logic [RETRY_W-1:0]   retry_limit;
        logic [TIMEOUT_W-1:0] timeout_ticks;
        result_t              pending_results[$];
        int                   errors;

        function new();
            head          = 0;
            count         = 0;
            in_flight     = 0;
            retries       = '0;
            timer         = '0;
            armed         = 0;
            retry_limit   = RETRY_LIMIT_RST;
            timeout_ticks = TIMEOUT_TICKS_RST;
            errors        = 0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            if (idx == REG_RETRY_LIMIT)
                retry_limit = val[RETRY_W-1:0];
            else if (idx == REG_TIMEOUT_TICKS)
                timeout_ticks = val;
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        function int entries();
            return count;
        endfunction

        function logic [ID_W-1:0] front_id();
            return id_mem[head];
        endfunction

        function void push_result(logic kind, logic [TAG_W-1:0] tag, logic [ID_W-1:0] id,
                                  status_t st);
            result_t r;
            r.kind   = kind;
            r.tag    = tag;
            r.id     = id;
            r.status = st;
            pending_results.insert(pending_results.size(), r);
        endfunction

        // Completion pops the front and drops the timer
        function void complete_front(status_t st);
            push_result(KIND_DONE, tag_mem[head], id_mem[head], st);
            head      = (head + 1) % QDEPTH;
            count--;
            in_flight = 0;
            armed     = 0;
            timer     = '0;
        endfunction

        function void transmit_front();
            push_result(KIND_TX, tag_mem[head], id_mem[head], ST_SUCCESS);
        endfunction

        // Update state for one accepted input word
        function void note_command(op_t cmd, logic [ID_W-1:0] id, logic [TAG_W-1:0] tag,
                                   logic [CODE_W-1:0] code, logic link);
            int unsigned slot;
            if (cmd == OP_ENQUEUE) begin
                if (count >= QDEPTH) begin
                    push_result(KIND_DONE, tag, id, ST_QFULL);
                end else begin
                    slot          = (head + count) % QDEPTH;
                    id_mem[slot]  = id;
                    tag_mem[slot] = tag;
                    count++;
                end
                return;
            end
            if (count == 0)
                return;
            case (cmd)
                OP_ACK: begin
                    if (id_mem[head] != id)
                        return;
                    case (code)
                        ACK_ACCEPTED: complete_front(ST_SUCCESS);
                        ACK_TEMP_REJECT, ACK_DENIED, ACK_UNSUPPORTED, ACK_FAILED:
                            complete_front(ST_DENIED);
                        ACK_IN_PROGRESS: begin
                            timer = TIMER_W'(retries) * TIMER_W'(timeout_ticks);
                            armed = 1;
                        end
                        default: ;
                    endcase
                end
                OP_POLL: begin
                    if (in_flight)
                        return;
                    if (!link) begin
                        complete_front(ST_CONN_ERR);
                    end else begin
                        in_flight = 1;
                        retries   = retry_limit;
                        timer     = TIMER_W'(timeout_ticks);
                        armed     = 1;
                        transmit_front();
                    end
                end
                default: begin
                    // timer tick
                    if (!armed)
                        return;
                    if (timer > 1) begin
                        timer--;
                        return;
                    end
                    armed = 0;
                    timer = '0;
                    if (retries == 0) begin
                        complete_front(ST_TIMEOUT);
                    end else if (!link) begin
                        complete_front(ST_CONN_ERR);
                    end else begin
                        retries--;
                        timer = TIMER_W'(timeout_ticks);
                        armed = 1;
                        transmit_front();
                    end
                end
            endcase
        endfunction

        function void compare_field(string name, logic [ID_W-1:0] exp, logic [ID_W-1:0] act);
            if (exp !== act) begin
                $display("%0t: %s mismatch: expected %h, actual %h", $time, name, exp, act);
                errors++;
            end
        endfunction

        // Compare one result word against the oldest expectation
        function void check_word(logic kind, logic [TAG_W-1:0] tag, logic [ID_W-1:0] id,
                                 logic [STATUS_W-1:0] status);
            result_t r;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result: expected none, actual kind %b tag %h id %h st %0d",
                         $time, kind, tag, id, status);
                errors++;
                return;
            end
            r = pending_results[0];
            pending_results.delete(0);
            compare_field("out_kind", ID_W'(r.kind), ID_W'(kind));
            compare_field("out_tag", ID_W'(r.tag), ID_W'(tag));
            compare_field("out_command_id", r.id, id);
            compare_field("out_status", ID_W'(r.status), ID_W'(status));
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals and DUT
    // ------------------------------------------------------------------------
    logic                    aclk;
    logic                    aresetn;
    logic                    cfg_we;
    logic [CFG_IDX_W-1:0]    cfg_index;
    logic [CFG_DATA_W-1:0]   cfg_data;
    logic                    s_tvalid;
    logic                    s_tready;
    logic [S_TDATA_W-1:0]    s_tdata;
    logic [CMD_W-1:0]        s_tuser;
    logic                    m_tvalid;
    logic                    m_tready;
    logic [M_TDATA_W-1:0]    m_tdata;
    logic                    m_tuser;

    ack_retry_scoreboard sb;
    int unsigned         cycles;
    int unsigned         rx_stall;
    bit                  rx_burst;
    bit                  tx_burst;

    command_ack_retry_engine_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // 10 ns clock
    initial aclk = 1'b0;
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Run limit
    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("command_ack_retry_engine_unit_test failed");
            $finish;
        end
    end

    // Result side: random stalls, with stretches of none
    always @(negedge aclk) begin
        m_tready <= (rx_stall == 0);
        if (rx_stall != 0)
            rx_stall--;
    end

    // Result monitor
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_word(m_tuser, m_tdata[7:0], m_tdata[23:8], m_tdata[26:24]);
            if ($urandom_range(0, 31) == 0)
                rx_burst = !rx_burst;
            rx_stall = rx_burst ? 0 : $urandom_range(0, 15);
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus tasks
    // ------------------------------------------------------------------------

    // Drive one word after a random gap; returns at the accepting edge
    task automatic send_word(op_t cmd, logic [ID_W-1:0] id, logic [TAG_W-1:0] tag,
                             logic [CODE_W-1:0] code, logic link);
        int unsigned gap;
        if ($urandom_range(0, 31) == 0)
            tx_burst = !tx_burst;
        gap = tx_burst ? 0 : $urandom_range(0, 15);
        @(negedge aclk);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {7'b0, link, code, tag, id};
        do @(posedge aclk); while (!s_tready);
        sb.note_command(cmd, id, tag, code, link);
    endtask

    // Hold off the sender until every expected word is back
    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        drain();
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        sb.set_register(idx, val);
    endtask

    // Mostly well-formed traffic: acks usually target the front command
    task automatic send_random_word(int unsigned enq_pct);
        int unsigned       r;
        op_t               cmd;
        logic [ID_W-1:0]   id;
        logic [TAG_W-1:0]  tag;
        logic [CODE_W-1:0] code;
        logic              link;
        r = $urandom_range(0, 99);
        if (r < enq_pct)
            cmd = OP_ENQUEUE;
        else if (r < enq_pct + 25)
            cmd = OP_ACK;
        else if (r < enq_pct + 43)
            cmd = OP_POLL;
        else
            cmd = OP_TICK;
        id   = ID_W'($urandom);
        tag  = TAG_W'($urandom);
        code = ($urandom_range(0, 9) == 0) ? CODE_W'($urandom) : CODE_W'($urandom_range(0, 5));
        link = ($urandom_range(0, 7) != 0);
        if (cmd == OP_ACK && sb.entries() != 0 && $urandom_range(0, 4) != 0)
            id = sb.front_id();
        send_word(cmd, id, tag, code, link);
    endtask

    task automatic run_phase(logic [RETRY_W-1:0] retry_val, logic [TIMEOUT_W-1:0] tick_val,
                             int n, int unsigned enq_pct);
        write_register(REG_RETRY_LIMIT, CFG_DATA_W'(retry_val));
        write_register(REG_TIMEOUT_TICKS, tick_val);
        repeat (n) send_random_word(enq_pct);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        sb        = new();
        cycles    = 0;
        rx_stall  = 0;
        rx_burst  = 0;
        tx_burst  = 0;
        aresetn   = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = OP_ENQUEUE;
        m_tready  = 1'b0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Empty queue: ack, poll and tick do nothing
        send_word(OP_TICK, 16'h0000, 8'h00, ACK_ACCEPTED, 1'b1);
        send_word(OP_ACK, 16'h0000, 8'h00, ACK_ACCEPTED, 1'b1);
        send_word(OP_POLL, 16'h0000, 8'h00, ACK_ACCEPTED, 1'b1);
        // Refused link on first send
        send_word(OP_ENQUEUE, 16'hFFFF, 8'hFF, 8'hFF, 1'b1);
        send_word(OP_POLL, 16'h0000, 8'h00, ACK_ACCEPTED, 1'b0);
        // Ack before the front was sent
        send_word(OP_ENQUEUE, 16'h0000, 8'h00, 8'h00, 1'b0);
        send_word(OP_ACK, 16'h0000, 8'h00, ACK_ACCEPTED, 1'b0);
        // Send, repeated poll, foreign id, unknown code, in progress, denied
        send_word(OP_ENQUEUE, 16'h1234, 8'h5A, 8'h00, 1'b1);
        send_word(OP_POLL, 16'h0000, 8'h00, ACK_ACCEPTED, 1'b1);
        send_word(OP_POLL, 16'h0000, 8'h00, ACK_ACCEPTED, 1'b1);
        send_word(OP_ACK, 16'h4321, 8'h00, ACK_ACCEPTED, 1'b1);
        send_word(OP_ACK, 16'h1234, 8'h00, 8'hFF, 1'b1);
        send_word(OP_ACK, 16'h1234, 8'h00, ACK_IN_PROGRESS, 1'b1);
        send_word(OP_ACK, 16'h1234, 8'h00, ACK_DENIED, 1'b1);
        // Fill the queue, then one more
        for (int i = 0; i < QDEPTH; i++)
            send_word(OP_ENQUEUE, ID_W'(16'h0100 + i), TAG_W'(8'h80 | i), 8'h00, 1'b1);
        send_word(OP_ENQUEUE, 16'hBEEF, 8'hA5, 8'h00, 1'b1);

        // Fast timer: retransmit, timeout, refused retransmit, denied codes
        write_register(REG_RETRY_LIMIT, 16'd1);
        write_register(REG_TIMEOUT_TICKS, 16'd1);
        write_register(REG_SPARE_2, CFG_DATA_W'($urandom));
        write_register(REG_SPARE_3, CFG_DATA_W'($urandom));
        send_word(OP_POLL, 16'h0000, 8'h00, ACK_ACCEPTED, 1'b1);
        send_word(OP_TICK, 16'h0000, 8'h00, ACK_ACCEPTED, 1'b1);
        send_word(OP_TICK, 16'h0000, 8'h00, ACK_ACCEPTED, 1'b1);
        send_word(OP_ACK, sb.front_id(), 8'h00, ACK_TEMP_REJECT, 1'b1);
        send_word(OP_ACK, sb.front_id(), 8'h00, ACK_UNSUPPORTED, 1'b1);
        send_word(OP_ACK, sb.front_id(), 8'h00, ACK_FAILED, 1'b1);
        send_word(OP_POLL, 16'h0000, 8'h00, ACK_ACCEPTED, 1'b1);
        send_word(OP_TICK, 16'h0000, 8'h00, ACK_ACCEPTED, 1'b0);

        // Random phases over a spread of settings, extremes included
        run_phase(4'd2, 16'd3, 150, 22);
        run_phase(4'd0, 16'd1, 100, 22);
        run_phase(4'd15, 16'd2, 120, 22);
        run_phase(4'd5, 16'd65535, 80, 22);
        run_phase(4'd1, 16'd5, 100, 45);
        run_phase(4'd4, 16'd0, 60, 22);

        // Wait out the last results
        drain();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("command_ack_retry_engine_unit_test passed");
        else
            $display("command_ack_retry_engine_unit_test failed");
        $finish;
    end

endmodule
